// ===== rtl/core/tcc_pkg.sv =====
`timescale 1ns / 1ps
package tcc_pkg;

	localparam int CELL_SIZE   = 8;
	localparam int CELL_SHIFT  = $clog2(CELL_SIZE);
	localparam int COORD_W     = 12;
	localparam int PIX_W       = 13;
	localparam int GRID_W      = COORD_W - CELL_SHIFT;
	localparam int COLOR_W     = 32;
	localparam int GLYPH_W     = 7;
	localparam int TARGET_W    = 16;
	localparam int HEX_W       = 32;
	localparam int NIB_COUNT   = HEX_W / 4;
	localparam int NIB_IDX_W   = $clog2(NIB_COUNT);
	localparam int ADDR_W      = 5;
	localparam int DATA_W      = 32;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [COORD_W-1:0] ORIGIN_X_RST    = 12'd8;
	localparam logic [COORD_W-1:0] ORIGIN_Y_RST    = 12'd28;
	localparam logic [COORD_W-1:0] AREA_WIDTH_RST  = 12'd624;
	localparam logic [COORD_W-1:0] AREA_HEIGHT_RST = 12'd444;
	localparam logic [COLOR_W-1:0] FORE_COLOR_RST  = 32'h00FF_FFFF;
	localparam logic [COLOR_W-1:0] BACK_COLOR_RST  = 32'h0000_0000;

	localparam logic [7:0] CH_BS    = 8'd8;
	localparam logic [7:0] CH_NL    = 8'd10;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_TILDE = 8'd126;
	localparam logic [7:0] CH_QMARK = "?";
	localparam logic [7:0] CH_ZERO  = "0";
	localparam logic [7:0] CH_X     = "x";
	localparam logic [3:0] NIB_MASK = 4'hF;
	localparam logic [127:0] HEX_DIGITS = "0123456789ABCDEF";

	typedef enum logic [1:0] {
		CMD_PUTC  = 2'd0,
		CMD_MOVE  = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_HEX   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		DRAW_GLYPH = 2'd0,
		DRAW_ERASE = 2'd1,
		DRAW_CLEAR = 2'd2
	} draw_op_t;

	typedef enum logic [2:0] {
		REG_ORIGIN_X    = 3'd0,
		REG_ORIGIN_Y    = 3'd1,
		REG_AREA_WIDTH  = 3'd2,
		REG_AREA_HEIGHT = 3'd3,
		REG_FORE_COLOR  = 3'd4,
		REG_BACK_COLOR  = 3'd5
	} reg_idx_t;

	typedef struct packed {
		cmd_t                        kind;
		logic [7:0]                  char_code;
		logic signed [TARGET_W-1:0]  target_col;
		logic signed [TARGET_W-1:0]  target_row;
		logic                        last;
	} qentry_t;

	typedef struct packed {
		logic [COORD_W-1:0] origin_x;
		logic [COORD_W-1:0] origin_y;
		logic [COORD_W-1:0] area_width;
		logic [COORD_W-1:0] area_height;
		logic [COLOR_W-1:0] fore_color;
		logic [COLOR_W-1:0] back_color;
	} cfg_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [6:0] pos;
		pos = {~nib, 3'b000};
		return HEX_DIGITS[pos +: 8];
	endfunction

endpackage

// ===== rtl/core/tcc_cmd_if.sv =====
`timescale 1ns / 1ps
interface tcc_cmd_if;
	import tcc_pkg::*;

	logic                       valid;
	logic                       ready;
	logic [1:0]                 command;
	logic [7:0]                 char_code;
	logic signed [TARGET_W-1:0] target_col;
	logic signed [TARGET_W-1:0] target_row;
	logic [HEX_W-1:0]           hex_value;

	modport source (
		output valid, command, char_code, target_col, target_row, hex_value,
		input  ready
	);

	modport sink (
		input  valid, command, char_code, target_col, target_row, hex_value,
		output ready
	);

endinterface

// ===== rtl/core/tcc_draw_if.sv =====
`timescale 1ns / 1ps
interface tcc_draw_if;
	import tcc_pkg::*;

	logic               valid;
	logic               ready;
	logic [1:0]         draw_op;
	logic [PIX_W-1:0]   pixel_x;
	logic [PIX_W-1:0]   pixel_y;
	logic [COORD_W-1:0] rect_width;
	logic [COORD_W-1:0] rect_height;
	logic [GLYPH_W-1:0] glyph;
	logic [COLOR_W-1:0] color;
	logic               last;

	modport source (
		output valid, draw_op, pixel_x, pixel_y, rect_width, rect_height, glyph, color, last,
		input  ready
	);

	modport sink (
		input  valid, draw_op, pixel_x, pixel_y, rect_width, rect_height, glyph, color, last,
		output ready
	);

endinterface

// ===== rtl/core/text_console_cursor_engine.sv =====
`timescale 1ns / 1ps
// channel   dir  handshake               payload
// cmd       in   valid / ready           command, char_code, target_col, target_row, hex_value
// draw      out  valid / ready           draw_op, pixel_x, pixel_y, rect_width, rect_height,
//                                        glyph, color, last
// apb       in   psel, penable, pready   paddr, pwdata, pwrite, prdata
//
// put character, move and clear go from idle into the queue, back to back while it has space.
// print hex holds the front for 3 to 10 characters, one per cycle while the queue has space.
// the back executes one queued character or command per cycle while the draw register is
// free; a clearing wrap issues the clear, then its glyph. a result reaches the draw port in
// the cycle after execution. a 4-entry queue splits front and back; the back stalls only on a
// full draw register. reset clears cursor, queue and output valid; no clearing pass is needed.
module text_console_cursor_engine (
	input  logic                       clk,
	input  logic                       arst_n,
	tcc_cmd_if.sink                    cmd,
	tcc_draw_if.source                 draw,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [tcc_pkg::ADDR_W-1:0] paddr,
	input  logic [tcc_pkg::DATA_W-1:0] pwdata,
	output logic [tcc_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);
	import tcc_pkg::*;

	cfg_t    cfg;
	logic    q_push, q_space, q_pop, q_valid;
	qentry_t q_in, q_head;

	tcc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tcc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.space      (q_space),
		.push       (q_push),
		.push_entry (q_in)
	);

	tcc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_in),
		.space      (q_space),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head       (q_head)
	);

	tcc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.q_valid (q_valid),
		.q_entry (q_head),
		.pop     (q_pop),
		.draw    (draw)
	);

	a_push_space: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> q_space)
		else $error("queue push while full");

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue pop while empty");

	a_direct_push: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready && cmd.command != CMD_HEX) |-> q_push)
		else $error("accepted command not queued");

	a_hex_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready && cmd.command == CMD_HEX) |=> !cmd.ready)
		else $error("front took an item while expanding hex");

endmodule

// ===== rtl/core/tcc_regs.sv =====
`timescale 1ns / 1ps
module tcc_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tcc_pkg::ADDR_W-1:0]  paddr,
	input  logic [tcc_pkg::DATA_W-1:0]  pwdata,
	output logic [tcc_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	output tcc_pkg::cfg_t               cfg
);
	import tcc_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr     = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x    <= ORIGIN_X_RST;
			cfg_q.origin_y    <= ORIGIN_Y_RST;
			cfg_q.area_width  <= AREA_WIDTH_RST;
			cfg_q.area_height <= AREA_HEIGHT_RST;
			cfg_q.fore_color  <= FORE_COLOR_RST;
			cfg_q.back_color  <= BACK_COLOR_RST;
		end else if (wr) begin
			case (idx)
				REG_ORIGIN_X:    cfg_q.origin_x    <= pwdata[COORD_W-1:0];
				REG_ORIGIN_Y:    cfg_q.origin_y    <= pwdata[COORD_W-1:0];
				REG_AREA_WIDTH:  cfg_q.area_width  <= pwdata[COORD_W-1:0];
				REG_AREA_HEIGHT: cfg_q.area_height <= pwdata[COORD_W-1:0];
				REG_FORE_COLOR:  cfg_q.fore_color  <= pwdata[COLOR_W-1:0];
				REG_BACK_COLOR:  cfg_q.back_color  <= pwdata[COLOR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_ORIGIN_X:    prdata = DATA_W'(cfg_q.origin_x);
			REG_ORIGIN_Y:    prdata = DATA_W'(cfg_q.origin_y);
			REG_AREA_WIDTH:  prdata = DATA_W'(cfg_q.area_width);
			REG_AREA_HEIGHT: prdata = DATA_W'(cfg_q.area_height);
			REG_FORE_COLOR:  prdata = DATA_W'(cfg_q.fore_color);
			REG_BACK_COLOR:  prdata = DATA_W'(cfg_q.back_color);
			default:         prdata = '0;
		endcase
	end

endmodule

// ===== rtl/core/tcc_front.sv =====
`timescale 1ns / 1ps
module tcc_front (
	input  logic             clk,
	input  logic             arst_n,
	tcc_cmd_if.sink          cmd,
	input  logic             space,
	output logic             push,
	output tcc_pkg::qentry_t push_entry
);
	import tcc_pkg::*;

	typedef enum logic [1:0] {
		F_IDLE,
		F_X,
		F_DIGIT
	} fstate_t;

	fstate_t               state_q;
	logic [HEX_W-1:0]      hex_q;
	logic [NIB_IDX_W-1:0]  idx_q;
	logic [NIB_IDX_W-1:0]  lead;
	logic [3:0]            nib;
	logic                  is_hex;

	assign is_hex    = (cmd.command == CMD_HEX);
	assign cmd.ready = (state_q == F_IDLE) && space;
	assign nib       = hex_q[{idx_q, 2'b00} +: 4] & NIB_MASK;

	// highest nonzero digit, zero when the value is zero
	always_comb begin
		lead = '0;
		for (int i = 1; i < NIB_COUNT; i++) begin
			if (cmd.hex_value[i*4 +: 4] != 4'h0) begin
				lead = NIB_IDX_W'(i);
			end
		end
	end

	always_comb begin
		push                  = 1'b0;
		push_entry.kind       = CMD_PUTC;
		push_entry.char_code  = cmd.char_code;
		push_entry.target_col = cmd.target_col;
		push_entry.target_row = cmd.target_row;
		push_entry.last       = 1'b1;
		case (state_q)
			F_IDLE: begin
				push = cmd.valid && space;
				if (is_hex) begin
					push_entry.char_code = CH_ZERO;
					push_entry.last      = 1'b0;
				end else begin
					push_entry.kind = cmd_t'(cmd.command);
				end
			end
			F_X: begin
				push                 = space;
				push_entry.char_code = CH_X;
				push_entry.last      = 1'b0;
			end
			F_DIGIT: begin
				push                 = space;
				push_entry.char_code = hex_char(nib);
				push_entry.last      = (idx_q == '0);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			hex_q   <= '0;
			idx_q   <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (cmd.valid && cmd.ready && is_hex) begin
						state_q <= F_X;
						hex_q   <= cmd.hex_value;
						idx_q   <= lead;
					end
				end
				F_X: begin
					if (space) begin
						state_q <= F_DIGIT;
					end
				end
				F_DIGIT: begin
					if (space) begin
						if (idx_q == '0) begin
							state_q <= F_IDLE;
						end else begin
							idx_q <= idx_q - 1'b1;
						end
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/core/tcc_queue.sv =====
`timescale 1ns / 1ps
module tcc_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  tcc_pkg::qentry_t push_entry,
	output logic             space,
	input  logic             pop,
	output logic             head_valid,
	output tcc_pkg::qentry_t head
);
	import tcc_pkg::*;

	qentry_t           mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_push;
	logic              do_pop;

	assign space      = (count_q != (QPTR_W+1)'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = push && space;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/core/tcc_back.sv =====
`timescale 1ns / 1ps
module tcc_back (
	input  logic             clk,
	input  logic             arst_n,
	input  tcc_pkg::cfg_t    cfg,
	input  logic             q_valid,
	input  tcc_pkg::qentry_t q_entry,
	output logic             pop,
	tcc_draw_if.source       draw
);
	import tcc_pkg::*;

	logic [GRID_W-1:0]  col_q, row_q;
	logic               phase_q;
	logic [GRID_W-1:0]  col_n, row_n, dcol, drow, cols, rows;
	logic               phase_n;
	logic [GRID_W:0]    row_inc;
	logic               nl_clear, wrap, printable;
	logic               emits, done, fire, out_free;
	draw_op_t           op_n;
	logic [GLYPH_W-1:0] glyph_n;
	logic               last_n;

	logic               valid_q;
	draw_op_t           op_q;
	logic [PIX_W-1:0]   x_q, y_q;
	logic [COORD_W-1:0] w_q, h_q;
	logic [GLYPH_W-1:0] glyph_q;
	logic [COLOR_W-1:0] color_q;
	logic               last_q;

	function automatic logic [GRID_W-1:0] clamp(
		input logic signed [TARGET_W-1:0] t,
		input logic [GRID_W-1:0]          n
	);
		logic signed [TARGET_W-1:0] lim;
		lim = $signed(TARGET_W'(n));
		if (t < 0 || n == '0) begin
			return '0;
		end else if (t >= lim) begin
			return n - 1'b1;
		end else begin
			return t[GRID_W-1:0];
		end
	endfunction

	function automatic logic [PIX_W-1:0] cell_pix(
		input logic [COORD_W-1:0] org,
		input logic [GRID_W-1:0]  idx
	);
		return PIX_W'(org) + (PIX_W'(idx) << CELL_SHIFT);
	endfunction

	assign cols      = cfg.area_width[COORD_W-1:CELL_SHIFT];
	assign rows      = cfg.area_height[COORD_W-1:CELL_SHIFT];
	assign row_inc   = {1'b0, row_q} + 1'b1;
	assign nl_clear  = (row_inc >= {1'b0, rows});
	assign wrap      = !phase_q && (col_q >= cols);
	assign printable = (q_entry.char_code >= CH_SPACE) && (q_entry.char_code <= CH_TILDE);

	always_comb begin
		col_n   = col_q;
		row_n   = row_q;
		phase_n = phase_q;
		dcol    = col_q;
		drow    = row_q;
		emits   = 1'b0;
		done    = 1'b1;
		op_n    = DRAW_GLYPH;
		glyph_n = '0;
		case (q_entry.kind)
			CMD_MOVE: begin
				col_n = clamp(q_entry.target_col, cols);
				row_n = clamp(q_entry.target_row, rows);
			end
			CMD_CLEAR: begin
				emits = 1'b1;
				op_n  = DRAW_CLEAR;
				col_n = '0;
				row_n = '0;
			end
			CMD_PUTC: begin
				if (q_entry.char_code == CH_NL) begin
					col_n = '0;
					if (nl_clear) begin
						emits = 1'b1;
						op_n  = DRAW_CLEAR;
						row_n = '0;
					end else begin
						row_n = row_inc[GRID_W-1:0];
					end
				end else if (q_entry.char_code == CH_BS) begin
					if (col_q != '0) begin
						dcol  = col_q - 1'b1;
						col_n = dcol;
						emits = 1'b1;
						op_n  = DRAW_ERASE;
					end
				end else if (wrap && nl_clear) begin
					// wrap runs off the bottom: clear now, then the glyph at home once the draw register is free
					emits   = 1'b1;
					op_n    = DRAW_CLEAR;
					col_n   = '0;
					row_n   = '0;
					phase_n = 1'b1;
					done    = 1'b0;
				end else begin
					dcol    = wrap ? '0 : col_q;
					drow    = wrap ? row_inc[GRID_W-1:0] : row_q;
					emits   = 1'b1;
					op_n    = DRAW_GLYPH;
					glyph_n = printable ? q_entry.char_code[GLYPH_W-1:0]
					                    : CH_QMARK[GLYPH_W-1:0];
					col_n   = dcol + 1'b1;
					row_n   = drow;
					phase_n = 1'b0;
				end
			end
			default: ;
		endcase
	end

	assign last_n   = q_entry.last && done;
	assign out_free = !valid_q || draw.ready;
	assign fire     = q_valid && (!emits || out_free);
	assign pop      = fire && done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			phase_q <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (fire) begin
				col_q   <= col_n;
				row_q   <= row_n;
				phase_q <= phase_n;
			end
			if (fire && emits) begin
				valid_q <= 1'b1;
			end else if (draw.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emits) begin
			op_q    <= op_n;
			glyph_q <= glyph_n;
			last_q  <= last_n;
			if (op_n == DRAW_CLEAR) begin
				x_q     <= PIX_W'(cfg.origin_x);
				y_q     <= PIX_W'(cfg.origin_y);
				w_q     <= cfg.area_width;
				h_q     <= cfg.area_height;
				color_q <= cfg.back_color;
			end else begin
				x_q     <= cell_pix(cfg.origin_x, dcol);
				y_q     <= cell_pix(cfg.origin_y, drow);
				w_q     <= COORD_W'(CELL_SIZE);
				h_q     <= COORD_W'(CELL_SIZE);
				color_q <= (op_n == DRAW_GLYPH) ? cfg.fore_color : cfg.back_color;
			end
		end
	end

	assign draw.valid       = valid_q;
	assign draw.draw_op     = op_q;
	assign draw.pixel_x     = x_q;
	assign draw.pixel_y     = y_q;
	assign draw.rect_width  = w_q;
	assign draw.rect_height = h_q;
	assign draw.glyph       = glyph_q;
	assign draw.color       = color_q;
	assign draw.last        = last_q;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
	import tcc_pkg::*;

	localparam int      SETTLE_CYCLES = 40;
	localparam int      HOLD_CYCLES   = 300;
	localparam longint  RUN_LIMIT_NS  = 20_000_000;
	localparam logic [7:0] CH_UPPER_A = "A";

	typedef struct {
		cmd_t                       kind;
		logic [7:0]                 code;
		logic signed [TARGET_W-1:0] tcol;
		logic signed [TARGET_W-1:0] trow;
		logic [HEX_W-1:0]           hex_val;
	} console_cmd_t;

	typedef struct {
		draw_op_t           op;
		logic [PIX_W-1:0]   x;
		logic [PIX_W-1:0]   y;
		logic [COORD_W-1:0] w;
		logic [COORD_W-1:0] h;
		logic [GLYPH_W-1:0] glyph;
		logic [COLOR_W-1:0] color;
		logic               last;
	} draw_rec_t;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [ADDR_W-1:0]  paddr;
	logic [DATA_W-1:0]  pwdata;
	logic [DATA_W-1:0]  prdata;
	logic               pready;

	tcc_cmd_if  cmd_ch ();
	tcc_draw_if draw_ch ();

	text_console_cursor_engine uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_ch),
		.draw    (draw_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// console shadow: registers and cursor
	cfg_t        shadow_cfg;
	int unsigned cur_col;
	int unsigned cur_row;

	draw_rec_t   item_draws[$];
	draw_rec_t   pending_draws[$];

	int  fault_count;
	int  checked_count;
	int  sent_count;
	int  config_count;
	bit  quiet;
	bit  hold_request;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("** text_console_cursor_engine: FAILED **");
		$finish;
	end

	function automatic void note_fault(input string msg);
		fault_count++;
		if (fault_count <= 10)
			$display("mismatch: %s", msg);
	endfunction

	function automatic int unsigned grid_cols();
		return shadow_cfg.area_width / CELL_SIZE;
	endfunction

	function automatic int unsigned grid_rows();
		return shadow_cfg.area_height / CELL_SIZE;
	endfunction

	function automatic void put_draw(input draw_op_t op, input int unsigned x,
			input int unsigned y, input int unsigned w, input int unsigned h,
			input int unsigned g, input logic [COLOR_W-1:0] c);
		draw_rec_t r;
		r.op    = op;
		r.x     = x[PIX_W-1:0];
		r.y     = y[PIX_W-1:0];
		r.w     = w[COORD_W-1:0];
		r.h     = h[COORD_W-1:0];
		r.glyph = g[GLYPH_W-1:0];
		r.color = c;
		r.last  = 1'b0;
		item_draws.push_back(r);
	endfunction

	function automatic void clear_area();
		put_draw(DRAW_CLEAR, 32'(shadow_cfg.origin_x), 32'(shadow_cfg.origin_y),
			32'(shadow_cfg.area_width), 32'(shadow_cfg.area_height), 0,
			shadow_cfg.back_color);
		cur_col = 0;
		cur_row = 0;
	endfunction

	function automatic void line_feed();
		cur_col = 0;
		cur_row++;
		if (cur_row >= grid_rows())
			clear_area();
	endfunction

	function automatic void put_char(input logic [7:0] c);
		logic [7:0] g;
		if (c == CH_NL) begin
			line_feed();
		end else if (c == CH_BS) begin
			if (cur_col > 0) begin
				cur_col--;
				put_draw(DRAW_ERASE, shadow_cfg.origin_x + cur_col * CELL_SIZE,
					shadow_cfg.origin_y + cur_row * CELL_SIZE, CELL_SIZE, CELL_SIZE, 0,
					shadow_cfg.back_color);
			end
		end else begin
			g = (c < CH_SPACE || c > CH_TILDE) ? CH_QMARK : c;
			if (cur_col >= grid_cols())
				line_feed();
			put_draw(DRAW_GLYPH, shadow_cfg.origin_x + cur_col * CELL_SIZE,
				shadow_cfg.origin_y + cur_row * CELL_SIZE, CELL_SIZE, CELL_SIZE, 32'(g),
				shadow_cfg.fore_color);
			cur_col++;
		end
	endfunction

	function automatic int unsigned clamp_cell(input logic signed [TARGET_W-1:0] t,
			input int unsigned count);
		int v;
		int top;
		v   = int'(t);
		top = int'(count) - 1;
		if (v > top)
			v = top;
		if (v < 0)
			v = 0;
		return v;
	endfunction

	function automatic logic [7:0] digit_code(input logic [3:0] nib);
		return (nib < 10) ? CH_ZERO + nib : CH_UPPER_A + nib - 8'd10;
	endfunction

	function automatic void predict_command(input console_cmd_t c);
		logic [3:0] nib;
		bit         started;
		item_draws.delete();
		case (c.kind)
			CMD_PUTC: put_char(c.code);
			CMD_MOVE: begin
				cur_col = clamp_cell(c.tcol, grid_cols());
				cur_row = clamp_cell(c.trow, grid_rows());
			end
			CMD_CLEAR: clear_area();
			CMD_HEX: begin
				started = 1'b0;
				put_char(CH_ZERO);
				put_char(CH_X);
				for (int i = NIB_COUNT - 1; i >= 0; i--) begin
					nib = c.hex_val[i*4 +: 4];
					if (nib != 0 || started || i == 0) begin
						put_char(digit_code(nib));
						started = 1'b1;
					end
				end
			end
			default: ;
		endcase
		if (item_draws.size() > 0)
			item_draws[$].last = 1'b1;
		foreach (item_draws[i])
			pending_draws.push_back(item_draws[i]);
	endfunction

	always @(posedge clk) begin : draw_checker
		draw_rec_t want;
		if (draw_ch.valid === 1'b1 && draw_ch.ready === 1'b1) begin
			if (pending_draws.size() == 0) begin
				note_fault($sformatf("unexpected draw op=%0d x=%0d y=%0d glyph=%0d",
					draw_ch.draw_op, draw_ch.pixel_x, draw_ch.pixel_y, draw_ch.glyph));
			end else begin
				want = pending_draws.pop_front();
				checked_count++;
				if (draw_ch.draw_op !== want.op || draw_ch.pixel_x !== want.x ||
						draw_ch.pixel_y !== want.y || draw_ch.rect_width !== want.w ||
						draw_ch.rect_height !== want.h || draw_ch.glyph !== want.glyph ||
						draw_ch.color !== want.color || draw_ch.last !== want.last)
					note_fault($sformatf({"draw %0d: expected op=%0d x=%0d y=%0d w=%0d h=%0d ",
						"g=%0d c=%h l=%b, got op=%0d x=%0d y=%0d w=%0d h=%0d g=%0d c=%h l=%b"},
						checked_count, want.op, want.x, want.y, want.w, want.h, want.glyph,
						want.color, want.last, draw_ch.draw_op, draw_ch.pixel_x,
						draw_ch.pixel_y, draw_ch.rect_width, draw_ch.rect_height,
						draw_ch.glyph, draw_ch.color, draw_ch.last));
			end
		end
	end

	// draw side: random stalls, one long hold on request
	initial begin : draw_sink
		int n;
		draw_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				draw_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
				draw_ch.ready <= 1'b1;
			end else if (!quiet && $urandom_range(0, 6) == 0) begin
				n = $urandom_range(1, 14);
				draw_ch.ready <= 1'b0;
				repeat (n) @(posedge clk);
				draw_ch.ready <= 1'b1;
			end else begin
				draw_ch.ready <= 1'b1;
			end
		end
	end

	task automatic send_cmd(input console_cmd_t c);
		int gap;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 14);
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid      <= 1'b1;
		cmd_ch.command    <= c.kind;
		cmd_ch.char_code  <= c.code;
		cmd_ch.target_col <= c.tcol;
		cmd_ch.target_row <= c.trow;
		cmd_ch.hex_value  <= c.hex_val;
		@(posedge clk);
		while (cmd_ch.ready !== 1'b1) @(posedge clk);
		predict_command(c);
		sent_count++;
	endtask

	task automatic drain_draws();
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_draws.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_xfer(input reg_idx_t idx, input logic wr,
			input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1) @(posedge clk);
		rdata = prdata;
	endtask

	function automatic logic [DATA_W-1:0] reg_value(input reg_idx_t idx);
		case (idx)
			REG_ORIGIN_X:    return DATA_W'(shadow_cfg.origin_x);
			REG_ORIGIN_Y:    return DATA_W'(shadow_cfg.origin_y);
			REG_AREA_WIDTH:  return DATA_W'(shadow_cfg.area_width);
			REG_AREA_HEIGHT: return DATA_W'(shadow_cfg.area_height);
			REG_FORE_COLOR:  return shadow_cfg.fore_color;
			default:         return shadow_cfg.back_color;
		endcase
	endfunction

	task automatic read_back(input reg_idx_t idx);
		logic [DATA_W-1:0] rd;
		apb_xfer(idx, 1'b0, '0, rd);
		if (rd !== reg_value(idx))
			note_fault($sformatf("register %s: expected %h, read %h", idx.name(),
				reg_value(idx), rd));
	endtask

	task automatic set_console(input logic [11:0] ox, input logic [11:0] oy,
			input logic [11:0] aw, input logic [11:0] ah,
			input logic [31:0] fg, input logic [31:0] bg);
		logic [DATA_W-1:0] vals[6];
		logic [DATA_W-1:0] rd;
		reg_idx_t          idx;
		vals = '{DATA_W'(ox), DATA_W'(oy), DATA_W'(aw), DATA_W'(ah), fg, bg};
		for (int i = 0; i < 6; i++) begin
			idx = reg_idx_t'(i);
			apb_xfer(idx, 1'b1, vals[i], rd);
			case (idx)
				REG_ORIGIN_X:    shadow_cfg.origin_x    = vals[i][COORD_W-1:0];
				REG_ORIGIN_Y:    shadow_cfg.origin_y    = vals[i][COORD_W-1:0];
				REG_AREA_WIDTH:  shadow_cfg.area_width  = vals[i][COORD_W-1:0];
				REG_AREA_HEIGHT: shadow_cfg.area_height = vals[i][COORD_W-1:0];
				REG_FORE_COLOR:  shadow_cfg.fore_color  = vals[i];
				default:         shadow_cfg.back_color  = vals[i];
			endcase
			read_back(idx);
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		config_count++;
	endtask

	function automatic console_cmd_t mk(input cmd_t kind, input logic [7:0] code,
			input int tcol, input int trow, input logic [31:0] hex_val);
		console_cmd_t c;
		c.kind    = kind;
		c.code    = code;
		c.tcol    = TARGET_W'(tcol);
		c.trow    = TARGET_W'(trow);
		c.hex_val = hex_val;
		return c;
	endfunction

	function automatic console_cmd_t random_cmd();
		console_cmd_t c;
		int           pick;
		c.code    = 8'($urandom);
		c.tcol    = TARGET_W'($urandom);
		c.trow    = TARGET_W'($urandom);
		c.hex_val = $urandom;
		pick = $urandom_range(0, 99);
		if (pick < 50) begin
			c.kind = CMD_PUTC;
			case ($urandom_range(0, 9))
				0:       c.code = CH_NL;
				1:       c.code = CH_BS;
				2, 3:    ;
				default: c.code = 8'($urandom_range(CH_SPACE, CH_TILDE));
			endcase
		end else if (pick < 65) begin
			c.kind = CMD_MOVE;
			if ($urandom_range(0, 3) != 0) begin
				c.tcol = TARGET_W'($urandom_range(0, grid_cols() + 1));
				c.trow = TARGET_W'($urandom_range(0, grid_rows() + 1));
			end
		end else if (pick < 70) begin
			c.kind = CMD_CLEAR;
		end else begin
			c.kind    = CMD_HEX;
			c.hex_val = c.hex_val >> (4 * $urandom_range(0, NIB_COUNT));
		end
		return c;
	endfunction

	task automatic test_reset_state();
		for (int i = 0; i < 6; i++)
			read_back(reg_idx_t'(i));
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_directed_commands();
		send_cmd(mk(CMD_PUTC, "A", 0, 0, 0));
		send_cmd(mk(CMD_PUTC, CH_SPACE, 0, 0, 0));
		send_cmd(mk(CMD_PUTC, CH_TILDE, 0, 0, 0));
		send_cmd(mk(CMD_PUTC, 8'd31, 0, 0, 0));
		send_cmd(mk(CMD_PUTC, 8'd127, 0, 0, 0));
		send_cmd(mk(CMD_PUTC, 8'd0, 0, 0, 0));
		send_cmd(mk(CMD_PUTC, 8'd255, 0, 0, 0));
		send_cmd(mk(CMD_PUTC, CH_BS, 0, 0, 0));
		send_cmd(mk(CMD_PUTC, CH_NL, 0, 0, 0));
		send_cmd(mk(CMD_PUTC, CH_BS, 0, 0, 0));
		send_cmd(mk(CMD_MOVE, 0, -32768, -32768, 0));
		send_cmd(mk(CMD_MOVE, 0, 32767, 32767, 0));
		send_cmd(mk(CMD_PUTC, "Z", 0, 0, 0));
		send_cmd(mk(CMD_PUTC, "Y", 0, 0, 0));
		send_cmd(mk(CMD_MOVE, 0, 3, 32767, 0));
		send_cmd(mk(CMD_PUTC, CH_NL, 0, 0, 0));
		send_cmd(mk(CMD_PUTC, "q", 0, 0, 0));
		send_cmd(mk(CMD_CLEAR, 0, 0, 0, 0));
		send_cmd(mk(CMD_HEX, 0, 0, 0, 32'h0000_0000));
		send_cmd(mk(CMD_HEX, 0, 0, 0, 32'hFFFF_FFFF));
		send_cmd(mk(CMD_HEX, 0, 0, 0, 32'h0001_0000));
		send_cmd(mk(CMD_HEX, 0, 0, 0, 32'h8000_0000));
		drain_draws();
	endtask

	task automatic test_grid_extremes();
		// cursor left far outside a grid that then shrinks to one cell
		send_cmd(mk(CMD_MOVE, 0, 60, 40, 0));
		drain_draws();
		set_console(12'hFFF, 12'hFFF, 12'd8, 12'd8, 32'h0, 32'hFFFF_FFFF);
		send_cmd(mk(CMD_PUTC, "a", 0, 0, 0));
		send_cmd(mk(CMD_PUTC, "b", 0, 0, 0));
		send_cmd(mk(CMD_PUTC, CH_BS, 0, 0, 0));
		send_cmd(mk(CMD_HEX, 0, 0, 0, 32'h1234_5678));
		drain_draws();
		// area smaller than one cell
		set_console(12'd100, 12'd200, 12'd4, 12'd0, 32'h00A5_5A5A, 32'h5A00_A5A5);
		send_cmd(mk(CMD_MOVE, 0, 5, 5, 0));
		send_cmd(mk(CMD_PUTC, "c", 0, 0, 0));
		send_cmd(mk(CMD_PUTC, "d", 0, 0, 0));
		send_cmd(mk(CMD_PUTC, CH_NL, 0, 0, 0));
		send_cmd(mk(CMD_HEX, 0, 0, 0, 32'h0000_00AB));
		drain_draws();
		// largest area
		set_console(12'd0, 12'd0, 12'hFFF, 12'hFFF, 32'hFFFF_FFFF, 32'h0);
		send_cmd(mk(CMD_MOVE, 0, 32767, 32767, 0));
		send_cmd(mk(CMD_PUTC, "e", 0, 0, 0));
		send_cmd(mk(CMD_PUTC, "f", 0, 0, 0));
		send_cmd(mk(CMD_MOVE, 0, -1, -1, 0));
		send_cmd(mk(CMD_HEX, 0, 0, 0, 32'hFEDC_BA98));
		drain_draws();
	endtask

	task automatic test_random_phases();
		logic [11:0] aw;
		logic [11:0] ah;
		for (int p = 0; p < 5; p++) begin
			aw = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(8, 4095))
			                                 : 12'($urandom_range(8, 96));
			ah = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(8, 4095))
			                                 : 12'($urandom_range(8, 64));
			set_console(12'($urandom), 12'($urandom), aw, ah, $urandom, $urandom);
			repeat (45) send_cmd(random_cmd());
			drain_draws();
		end
	endtask

	task automatic test_input_stall();
		console_cmd_t c;
		hold_request = 1'b1;
		repeat (16) begin
			c = random_cmd();
			c.kind = CMD_HEX;
			send_cmd(c);
		end
		drain_draws();
		while (hold_request) @(posedge clk);
	endtask

	task automatic test_back_to_back();
		quiet = 1'b1;
		set_console(ORIGIN_X_RST, ORIGIN_Y_RST, 12'd40, 12'd24, FORE_COLOR_RST, BACK_COLOR_RST);
		repeat (40) send_cmd(random_cmd());
		drain_draws();
	endtask

	initial begin
		arst_n               <= 1'b0;
		cmd_ch.valid         <= 1'b0;
		cmd_ch.command       <= CMD_PUTC;
		cmd_ch.char_code     <= '0;
		cmd_ch.target_col    <= '0;
		cmd_ch.target_row    <= '0;
		cmd_ch.hex_value     <= '0;
		psel                 <= 1'b0;
		penable              <= 1'b0;
		pwrite               <= 1'b0;
		paddr                <= '0;
		pwdata               <= '0;
		shadow_cfg.origin_x    = ORIGIN_X_RST;
		shadow_cfg.origin_y    = ORIGIN_Y_RST;
		shadow_cfg.area_width  = AREA_WIDTH_RST;
		shadow_cfg.area_height = AREA_HEIGHT_RST;
		shadow_cfg.fore_color  = FORE_COLOR_RST;
		shadow_cfg.back_color  = BACK_COLOR_RST;
		cur_col       = 0;
		cur_row       = 0;
		fault_count   = 0;
		checked_count = 0;
		sent_count    = 0;
		config_count  = 0;
		quiet         = 1'b0;
		hold_request  = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_directed_commands();
		test_grid_extremes();
		test_random_phases();
		test_input_stall();
		test_back_to_back();

		if (pending_draws.size() != 0)
			note_fault($sformatf("%0d draws never arrived", pending_draws.size()));
		$display("run covered %0d commands and %0d checked draws over %0d register settings",
			sent_count, checked_count, config_count);
		$display("including wraps, area clears, clamped moves and a long draw-side hold");
		if (fault_count == 0) begin
			$display("** text_console_cursor_engine: PASSED **");
		end else begin
			$display("%0d mismatches", fault_count);
			$display("** text_console_cursor_engine: FAILED **");
		end
		$finish;
	end

endmodule
